// ===== design/point_to_segment_distance_core_defines.svh =====
`ifndef POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`define POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define P2S_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define P2S_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication that is also checked across reset
`define P2S_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/p2s_pkg.sv =====
`default_nettype none

package p2s_pkg;

   typedef logic [1:0] region_type;

   localparam region_type REGION_DEGEN    = 2'd0;
   localparam region_type REGION_BEFORE   = 2'd1;
   localparam region_type REGION_INTERIOR = 2'd2;
   localparam region_type REGION_BEYOND   = 2'd3;

   // control that travels with each pipeline slot
   typedef struct packed {
      logic       valid;
      region_type region;
   } tag_type;

endpackage

`default_nettype wire

// ===== design/p2s_front.sv =====
`default_nettype none

module p2s_front #(
   parameter int W = 16,
   parameter int F = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [6*W-1:0]       in_data,
   output p2s_pkg::tag_type     out_tag,
   output logic [4*W+2+2*F-1:0] out_num,
   output logic [2*W:0]         out_den
);

   localparam int PW = 2*W + 2;
   localparam int SW = 2*W + 3;
   localparam int MW = 2*W + 1;
   localparam int NW = 4*W + 2 + 2*F;

   logic [W-1:0] px, py, sx, sy, ex, ey;

   // stage 1: differences
   logic signed [W:0] dx_in, dy_in, vx_in, vy_in, wx_in, wy_in;
   logic signed [W:0] dx_ff, dy_ff, vx_ff, vy_ff, wx_ff, wy_ff;
   logic              v1_ff;
   // stage 2: products
   logic signed [PW-1:0] pddx_in, pddy_in, pvdx_in, pvdy_in, pca_in, pcb_in;
   logic signed [PW-1:0] pvvx_in, pvvy_in, pwwx_in, pwwy_in;
   logic signed [PW-1:0] pddx_ff, pddy_ff, pvdx_ff, pvdy_ff, pca_ff, pcb_ff;
   logic signed [PW-1:0] pvvx_ff, pvvy_ff, pwwx_ff, pwwy_ff;
   logic                 v2_ff;
   // stage 3: sums
   logic signed [SW-1:0] den_in, dot_in, cross_in, sqv_in, sqw_in;
   logic signed [SW-1:0] den_ff, dot_ff, cross_ff, sqv_ff, sqw_ff;
   logic                 v3_ff;
   // stage 4: region and operand select
   p2s_pkg::region_type  region_in;
   logic signed [SW-1:0] cross_abs;
   logic [MW-1:0]        mag_in, sq_in, den4_in;
   logic [MW-1:0]        mag_ff, sq_ff, den4_ff;
   p2s_pkg::tag_type     tag4_ff;
   // stage 5: dividend and divisor
   logic [2*MW-1:0]      prod;
   logic [NW-1:0]        num_in, num_ff;
   logic [MW-1:0]        den5_in, den5_ff;
   p2s_pkg::tag_type     tag5_ff;
   logic                 interior;

   assign px = in_data[W-1:0];
   assign py = in_data[2*W-1:W];
   assign sx = in_data[3*W-1:2*W];
   assign sy = in_data[4*W-1:3*W];
   assign ex = in_data[5*W-1:4*W];
   assign ey = in_data[6*W-1:5*W];

   // stage 1 differences at one extra bit
   always_comb begin
      dx_in = $signed({ex[W-1], ex}) - $signed({sx[W-1], sx});
      dy_in = $signed({ey[W-1], ey}) - $signed({sy[W-1], sy});
      vx_in = $signed({px[W-1], px}) - $signed({sx[W-1], sx});
      vy_in = $signed({py[W-1], py}) - $signed({sy[W-1], sy});
      wx_in = $signed({px[W-1], px}) - $signed({ex[W-1], ex});
      wy_in = $signed({py[W-1], py}) - $signed({ey[W-1], ey});
   end

   // stage 2 all ten products in parallel
   always_comb begin
      pddx_in = dx_ff * dx_ff;
      pddy_in = dy_ff * dy_ff;
      pvdx_in = vx_ff * dx_ff;
      pvdy_in = vy_ff * dy_ff;
      pca_in  = vx_ff * dy_ff;
      pcb_in  = vy_ff * dx_ff;
      pvvx_in = vx_ff * vx_ff;
      pvvy_in = vy_ff * vy_ff;
      pwwx_in = wx_ff * wx_ff;
      pwwy_in = wy_ff * wy_ff;
   end

   // stage 3 dot, cross and squared lengths
   always_comb begin
      den_in   = $signed({pddx_ff[PW-1], pddx_ff}) + $signed({pddy_ff[PW-1], pddy_ff});
      dot_in   = $signed({pvdx_ff[PW-1], pvdx_ff}) + $signed({pvdy_ff[PW-1], pvdy_ff});
      cross_in = $signed({pca_ff[PW-1], pca_ff}) - $signed({pcb_ff[PW-1], pcb_ff});
      sqv_in   = $signed({pvvx_ff[PW-1], pvvx_ff}) + $signed({pvvy_ff[PW-1], pvvy_ff});
      sqw_in   = $signed({pwwx_ff[PW-1], pwwx_ff}) + $signed({pwwy_ff[PW-1], pwwy_ff});
   end

   // stage 4 region decision
   always_comb begin
      if (den_ff == '0) begin
         region_in = p2s_pkg::REGION_DEGEN;
      end else if (dot_ff < 0) begin
         region_in = p2s_pkg::REGION_BEFORE;
      end else if (dot_ff > den_ff) begin
         region_in = p2s_pkg::REGION_BEYOND;
      end else begin
         region_in = p2s_pkg::REGION_INTERIOR;
      end
      cross_abs = cross_ff[SW-1] ? -cross_ff : cross_ff;
      mag_in    = cross_abs[MW-1:0];
      sq_in     = (region_in == p2s_pkg::REGION_BEYOND) ? sqw_ff[MW-1:0] : sqv_ff[MW-1:0];
      den4_in   = den_ff[MW-1:0];
   end

   // stage 5 cross squared over den, or squared length over one
   always_comb begin
      interior = (tag4_ff.region == p2s_pkg::REGION_INTERIOR);
      prod     = mag_ff * mag_ff;
      if (interior) begin
         num_in  = NW'(prod) << (2*F);
         den5_in = den4_ff;
      end else begin
         num_in  = NW'(sq_ff) << (2*F);
         den5_in = MW'(1);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else if (adv) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         tag4_ff <= '{valid: v3_ff, region: region_in};
         tag5_ff <= tag4_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         pddx_ff  <= pddx_in;
         pddy_ff  <= pddy_in;
         pvdx_ff  <= pvdx_in;
         pvdy_ff  <= pvdy_in;
         pca_ff   <= pca_in;
         pcb_ff   <= pcb_in;
         pvvx_ff  <= pvvx_in;
         pvvy_ff  <= pvvy_in;
         pwwx_ff  <= pwwx_in;
         pwwy_ff  <= pwwy_in;
         den_ff   <= den_in;
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
         sqv_ff   <= sqv_in;
         sqw_ff   <= sqw_in;
         mag_ff   <= mag_in;
         sq_ff    <= sq_in;
         den4_ff  <= den4_in;
         num_ff   <= num_in;
         den5_ff  <= den5_in;
      end
   end

   assign out_tag = tag5_ff;
   assign out_num = num_ff;
   assign out_den = den5_ff;

endmodule

`default_nettype wire

// ===== design/p2s_divider.sv =====
`default_nettype none

// restoring divider, one quotient bit per stage
module p2s_divider #(
   parameter int W = 16,
   parameter int F = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  p2s_pkg::tag_type       in_tag,
   input  logic [4*W+2+2*F-1:0]   in_num,
   input  logic [2*W:0]           in_den,
   output p2s_pkg::tag_type       out_tag,
   output logic [2*W+2*F:0]       out_quot
);

   localparam int NW = 4*W + 2 + 2*F;
   localparam int QB = 2*W + 1 + 2*F;
   localparam int DV = 2*W + 1;

   logic [DV-1:0]    rem_ff [QB];
   logic [QB-1:0]    low_ff [QB];
   logic [DV-1:0]    den_ff [QB];
   p2s_pkg::tag_type tag_ff [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [DV-1:0]    rin;
      logic [QB-1:0]    lin;
      logic [DV-1:0]    din;
      p2s_pkg::tag_type tin;
      logic [DV:0]      trial;
      logic [DV:0]      diff;
      logic             ge;

      if (s == 0) begin : g_first
         // top part of the dividend is below the divisor
         always_comb begin
            rin = in_num[NW-1:QB];
            lin = in_num[QB-1:0];
            din = in_den;
            tin = in_tag;
         end
      end else begin : g_next
         always_comb begin
            rin = rem_ff[s-1];
            lin = low_ff[s-1];
            din = den_ff[s-1];
            tin = tag_ff[s-1];
         end
      end

      // trial subtract
      always_comb begin
         trial = {rin, lin[QB-1]};
         diff  = trial - {1'b0, din};
         ge    = (trial >= {1'b0, din});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (adv) begin
            tag_ff[s] <= tin;
         end
      end

      // quotient bits shift in as dividend bits shift out
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= ge ? diff[DV-1:0] : trial[DV-1:0];
            low_ff[s] <= {lin[QB-2:0], ge};
            den_ff[s] <= din;
         end
      end
   end

   assign out_tag  = tag_ff[QB-1];
   assign out_quot = low_ff[QB-1];

endmodule

`default_nettype wire

// ===== design/p2s_sqrt.sv =====
`default_nettype none

// digit-by-digit square root, one result bit per stage
module p2s_sqrt #(
   parameter int W = 16,
   parameter int F = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  p2s_pkg::tag_type   in_tag,
   input  logic [2*W+2*F:0]   in_rad,
   output p2s_pkg::tag_type   out_tag,
   output logic [W+F:0]       out_root
);

   localparam int DW = W + F + 1;
   localparam int RW = 2*DW;

   logic [DW+1:0]    rem_ff  [DW];
   logic [DW-1:0]    root_ff [DW];
   logic [RW-1:0]    rest_ff [DW];
   p2s_pkg::tag_type tag_ff  [DW];

   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [DW+1:0]    rin;
      logic [DW-1:0]    qin;
      logic [RW-1:0]    sin;
      p2s_pkg::tag_type tin;
      logic [DW+1:0]    trial;
      logic [DW+1:0]    tsub;
      logic             ge;

      if (s == 0) begin : g_first
         always_comb begin
            rin = '0;
            qin = '0;
            sin = RW'(in_rad);
            tin = in_tag;
         end
      end else begin : g_next
         always_comb begin
            rin = rem_ff[s-1];
            qin = root_ff[s-1];
            sin = rest_ff[s-1];
            tin = tag_ff[s-1];
         end
      end

      // bring down two radicand bits, try 4q+1
      always_comb begin
         trial = {rin[DW-1:0], sin[RW-1:RW-2]};
         tsub  = {qin, 2'b01};
         ge    = (trial >= tsub);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (adv) begin
            tag_ff[s] <= tin;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= ge ? (trial - tsub) : trial;
            root_ff[s] <= {qin[DW-2:0], ge};
            rest_ff[s] <= sin << 2;
         end
      end
   end

   assign out_tag  = tag_ff[DW-1];
   assign out_root = root_ff[DW-1];

endmodule

`default_nettype wire

// ===== design/point_to_segment_distance_core.sv =====
// throughput: one transaction per cycle while rsp_tready allows; the divider and root are
// fully pipelined, one bit per stage, so the stage count sets the latency
// backpressure: rsp_tready low with a valid result freezes every stage, req_tready follows it
// reset: synchronous, clears all stage valid bits; datapath is not reset
`default_nettype none

module point_to_segment_distance_core #(
   parameter int COORD_WIDTH     = 16,
   parameter int EXTRA_FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, start_x, start_y, end_x, end_y
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // distance
   output logic [((COORD_WIDTH+EXTRA_FRAC_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // region
   output logic [1:0] rsp_tuser
);

   localparam int W  = COORD_WIDTH;
   localparam int F  = EXTRA_FRAC_BITS;
   localparam int NW = 4*W + 2 + 2*F;
   localparam int QB = 2*W + 1 + 2*F;
   localparam int DW = W + F + 1;
   localparam int OW = ((DW+7)/8)*8;

   logic             adv;
   p2s_pkg::tag_type front_tag, div_tag, root_tag;
   logic [NW-1:0]    front_num;
   logic [2*W:0]     front_den;
   logic [QB-1:0]    quot;
   logic [DW-1:0]    root;

   // whole pipeline moves when the output slot is free or taken
   assign adv        = !root_tag.valid || rsp_tready;
   assign req_tready = adv;

   p2s_front #(.W(W), .F(F)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_data  (req_tdata[6*W-1:0]),
      .out_tag  (front_tag),
      .out_num  (front_num),
      .out_den  (front_den)
   );

   p2s_divider #(.W(W), .F(F)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (front_tag),
      .in_num   (front_num),
      .in_den   (front_den),
      .out_tag  (div_tag),
      .out_quot (quot)
   );

   p2s_sqrt #(.W(W), .F(F)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (div_tag),
      .in_rad   (quot),
      .out_tag  (root_tag),
      .out_root (root)
   );

   // last root stage is the output register
   assign rsp_tvalid = root_tag.valid;
   assign rsp_tdata  = OW'(root);
   assign rsp_tuser  = root_tag.region;

endmodule

`default_nettype wire

// ===== design/p2s_checker.sv =====
`default_nettype none
`include "point_to_segment_distance_core_defines.svh"

module p2s_checker #(
   parameter int COORD_WIDTH     = 16,
   parameter int EXTRA_FRAC_BITS = 8
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((COORD_WIDTH+EXTRA_FRAC_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);

   // a stalled result keeps its payload
   `P2S_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // input side is open exactly when the output slot moves
   `P2S_ASSERT_NOW(a_ready_follows, 1'b1, req_tready == (!rsp_tvalid || rsp_tready), "req_tready does not follow output slot")

   // reset empties the pipeline
   `P2S_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind point_to_segment_distance_core p2s_checker #(
   .COORD_WIDTH     (COORD_WIDTH),
   .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS)
) u_p2s_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int FRAC = 8;
   localparam int N_RANDOM = 1800;
   localparam int TAIL_CYCLES = 120;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [CW-1:0] px, py, sx, sy, ex, ey;
   } seg_query_type;

   typedef struct {
      logic [24:0]         distance;
      p2s_pkg::region_type region;
   } dist_result_type;

   typedef struct {
      seg_query_type   q;
      bit              typed;
      dist_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   dist_result_type pending_dist[$];
   int              fail_count = 0;
   longint          cycle_count = 0;
   bit              stim_done = 1'b0;

   point_to_segment_distance_core #(.COORD_WIDTH(CW), .EXTRA_FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   // largest q below 2^25 with q*q*den <= num
   function automatic logic [24:0] floor_root(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      logic [127:0] c;
      q = '0;
      for (int b = 24; b >= 0; b--) begin
         c = q | (128'd1 << b);
         if (c * c * den <= num) q = c;
      end
      return q[24:0];
   endfunction

   function automatic logic [24:0] scaled_len(longint ax, longint ay);
      logic [127:0] sq;
      sq = 128'(ax * ax + ay * ay);
      return floor_root(sq << (2 * FRAC), 128'd1);
   endfunction

   // exact fixed-point distance and region for one query
   function automatic dist_result_type predict_dist(seg_query_type q);
      dist_result_type r;
      longint dx, dy, vx, vy, den, dot, crs, cmag;
      logic [127:0] num;
      dx = longint'(q.ex) - longint'(q.sx);
      dy = longint'(q.ey) - longint'(q.sy);
      vx = longint'(q.px) - longint'(q.sx);
      vy = longint'(q.py) - longint'(q.sy);
      den = dx * dx + dy * dy;
      dot = vx * dx + vy * dy;
      if (den == 0) begin
         r.region = p2s_pkg::REGION_DEGEN;
         r.distance = scaled_len(vx, vy);
      end else if (dot < 0) begin
         r.region = p2s_pkg::REGION_BEFORE;
         r.distance = scaled_len(vx, vy);
      end else if (dot > den) begin
         r.region = p2s_pkg::REGION_BEYOND;
         r.distance = scaled_len(longint'(q.px) - longint'(q.ex),
                                 longint'(q.py) - longint'(q.ey));
      end else begin
         r.region = p2s_pkg::REGION_INTERIOR;
         crs = vx * dy - vy * dx;
         cmag = (crs < 0) ? -crs : crs;
         num = 128'(cmag) * 128'(cmag);
         r.distance = floor_root(num << (2 * FRAC), 128'(den));
      end
      return r;
   endfunction

   // mostly short gaps, a few long ones, sometimes none for a stretch
   function automatic int gap_len(bit busy_phase);
      int k;
      if (busy_phase) return 0;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(bit narrow);
      if (narrow) return CW'($signed($urandom_range(0, 64)) - 32);
      return CW'($urandom);
   endfunction

   function automatic seg_query_type rand_query();
      seg_query_type q;
      int kind;
      bit narrow;
      kind = $urandom_range(0, 99);
      narrow = (kind < 30);
      q.px = rand_coord(narrow); q.py = rand_coord(narrow);
      q.sx = rand_coord(narrow); q.sy = rand_coord(narrow);
      q.ex = rand_coord(narrow); q.ey = rand_coord(narrow);
      // degenerate segment
      if (kind >= 80 && kind < 88) begin
         q.ex = q.sx; q.ey = q.sy;
      end
      // point near a short segment, sometimes on it or right at an end point
      if (kind >= 88 && kind < 96) begin
         q.sx = rand_coord(1'b1); q.sy = rand_coord(1'b1);
         q.ex = CW'(q.sx + 4); q.ey = CW'(q.sy + 2);
         q.px = CW'(q.sx + 2 * CW'($signed($urandom_range(0, 6)) - 2));
         q.py = CW'(q.sy + CW'($signed($urandom_range(0, 6)) - 2));
      end
      // extreme corners
      if (kind >= 96) begin
         q.px = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         q.py = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         q.sx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         q.sy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         q.ex = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         q.ey = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      return q;
   endfunction

   // drive one transaction and hold it until accepted
   task automatic send_query(seg_query_type q, bit typed, dist_result_type typed_res);
      dist_result_type exp_res;
      req_tvalid <= 1'b1;
      req_tdata <= {q.ey, q.ex, q.sy, q.sx, q.py, q.px};
      do @(posedge clock); while (!req_tready);
      if (typed) begin
         exp_res = typed_res;
      end else begin
         exp_res = predict_dist(q);
      end
      pending_dist.push_back(exp_res);
   endtask

   function automatic stim_row_type row(int px, int py, int sx, int sy, int ex, int ey,
                                        bit typed, int distance, p2s_pkg::region_type rg);
      stim_row_type r;
      r.q.px = CW'(px); r.q.py = CW'(py); r.q.sx = CW'(sx);
      r.q.sy = CW'(sy); r.q.ex = CW'(ex); r.q.ey = CW'(ey);
      r.typed = typed;
      r.res.distance = 25'(distance);
      r.res.region = rg;
      return r;
   endfunction

   // row checked against the predictor
   function automatic stim_row_type calc_row(int px, int py, int sx, int sy, int ex, int ey);
      return row(px, py, sx, sy, ex, ey, 1'b0, 0, p2s_pkg::REGION_DEGEN);
   endfunction

   // stimulus: directed table, then random queries
   initial begin
      stim_row_type dir_rows[$];
      dist_result_type none;
      int g;
      bit busy;
      none.distance = '0;
      none.region = p2s_pkg::REGION_DEGEN;
      dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, p2s_pkg::REGION_DEGEN));
      dir_rows.push_back(row(3, 4, 0, 0, 0, 0, 1, 1280, p2s_pkg::REGION_DEGEN));
      dir_rows.push_back(row(-10, 0, 0, 0, 10, 0, 1, 2560, p2s_pkg::REGION_BEFORE));
      dir_rows.push_back(row(20, 0, 0, 0, 10, 0, 1, 2560, p2s_pkg::REGION_BEYOND));
      dir_rows.push_back(row(5, 7, 0, 0, 10, 0, 1, 1792, p2s_pkg::REGION_INTERIOR));
      dir_rows.push_back(row(0, 3, 0, 0, 10, 0, 1, 768, p2s_pkg::REGION_INTERIOR));
      dir_rows.push_back(row(10, 3, 0, 0, 10, 0, 1, 768, p2s_pkg::REGION_INTERIOR));
      dir_rows.push_back(row(1, 1, 0, 0, 2, 2, 1, 0, p2s_pkg::REGION_INTERIOR));
      dir_rows.push_back(calc_row(32767, 32767, -32768, -32768, -32768, -32768));
      dir_rows.push_back(calc_row(-32768, -32768, 32767, 32767, 32767, 32767));
      dir_rows.push_back(calc_row(-32768, 32767, -32768, -32768, 32767, 32767));
      dir_rows.push_back(calc_row(32767, -32768, -32768, -32768, 32767, 32767));
      dir_rows.push_back(calc_row(-32768, -32768, -32767, -32767, 32767, 32767));
      dir_rows.push_back(calc_row(32767, 32767, -32768, -32768, 32766, 32766));
      dir_rows.push_back(calc_row(0, 32767, -32768, 0, 32767, 0));
      dir_rows.push_back(calc_row(7, -3, 1, 2, 9, -5));
      dir_rows.push_back(calc_row(-1, -1, 0, 0, 1, 0));
      dir_rows.push_back(calc_row(2, -1, 0, 0, 1, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].res);
         g = gap_len(1'b0);
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      busy = 1'b0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 49) == 0) busy = ~busy;
         send_query(rand_query(), 1'b0, none);
         g = gap_len(busy);
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side stalls
   initial begin
      int g;
      bit busy;
      busy = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) busy = ~busy;
         g = gap_len(busy);
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dist.size() == 0) begin
            $display("%0t: unexpected result distance=%0d region=%0d",
                     $time, rsp_tdata[24:0], rsp_tuser);
            fail_count++;
         end else begin
            want = pending_dist.pop_front();
            if (rsp_tdata[24:0] !== want.distance) begin
               $display("%0t: distance mismatch expected %0d actual %0d",
                        $time, want.distance, rsp_tdata[24:0]);
               fail_count++;
            end
            if (rsp_tuser !== want.region) begin
               $display("%0t: region mismatch expected %0d actual %0d",
                        $time, want.region, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
